// ----- hdl/cdfd_pkg.sv -----
// constants, stage payload types and calendar tables for civil_date_from_days
// no dependencies; used by every module of the block
`default_nettype none

package cdfd_pkg;

   localparam int DAYS_W      = 32;
   localparam int YEAR_W      = 24;
   localparam int MONTH_W     = 4;
   localparam int MDAY_W      = 5;
   localparam int DOY_W       = 9;
   localparam int RSP_FIELDS_W = YEAR_W + MONTH_W + MDAY_W + DOY_W;
   localparam int RSP_DATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam longint REBASE_DAYS = 365 * 30 + 7;
   localparam longint DAYS_400Y   = 400 * 365 + 100 - 4 + 1;
   localparam longint DAYS_100Y   = 100 * 365 + 25 - 1;
   localparam longint DAYS_4Y     = 4 * 365 + 1;
   localparam longint DAYS_1Y     = 365;
   localparam longint DAYS_LEAP_Y = 366;
   localparam longint BASE_YEAR   = 2000;
   localparam longint YEARS_ERA   = 400;
   localparam longint YEARS_CENT  = 100;
   localparam longint YEARS_QUAD  = 4;

   // bias in whole eras so the day count is never negative
   localparam longint BIAS_ERAS   = 14700;
   localparam int     N_W         = DAYS_W + 1;
   localparam logic [N_W-1:0] N_OFFSET = N_W'(BIAS_ERAS * DAYS_400Y - REBASE_DAYS);

   // era quotient by reciprocal of the count shifted down by 8
   localparam int     N_DROP      = 8;
   localparam int     A_W         = N_W - N_DROP;
   localparam int     RECIP_SHIFT = 40;
   localparam int     RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP_400Y =
      RECIP_W'((longint'(1) << RECIP_SHIFT) / DAYS_400Y);
   localparam int     PROD_W      = A_W + RECIP_W;
   localparam int     Q_SHIFT     = RECIP_SHIFT - N_DROP;

   localparam int     Q_W    = 15;
   localparam int     CYC_W  = 16;
   localparam int     R0_W   = 20;
   localparam int     R_W    = 18;
   localparam int     R1_W   = 16;
   localparam int     R2_W   = 11;
   localparam int     CENT_W = 2;
   localparam int     QUAD_W = 5;
   localparam int     YR_W   = 2;
   localparam int     QUADS_PER_CENT = 24;
   localparam int     MONTHS = 12;

   typedef struct packed {
      logic             valid;
      logic [CYC_W-1:0] cyc;
      logic [R_W-1:0]   rem;
   } era_type;

   typedef struct packed {
      logic              valid;
      logic [CYC_W-1:0]  cyc;
      logic [CENT_W-1:0] cent;
      logic [QUAD_W-1:0] quad;
      logic [YR_W-1:0]   yr;
      logic [DOY_W-1:0]  doy;
   } split_type;

   // zero-based day of the year on which month idx (0 = january) starts
   function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                     input logic [MONTH_W-1:0] idx);
      logic [DOY_W-1:0] base;
      case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + DOY_W'(leap && (idx >= MONTH_W'(2)));
   endfunction

endpackage

`default_nettype wire

// ----- hdl/cdfd_era_split.sv -----
// four pipeline stages: rebias, reciprocal multiply, remainder, correction
// splits the day count into whole 400-year eras and the day within the era; uses cdfd_pkg
`default_nettype none

module cdfd_era_split (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic [cdfd_pkg::DAYS_W-1:0]  in_days,
   output cdfd_pkg::era_type                 era
);

   localparam logic [cdfd_pkg::R0_W-1:0] D1 = cdfd_pkg::R0_W'(cdfd_pkg::DAYS_400Y);
   localparam logic [cdfd_pkg::R0_W-1:0] D2 = cdfd_pkg::R0_W'(2 * cdfd_pkg::DAYS_400Y);

   logic                          a_valid_ff;
   logic [cdfd_pkg::N_W-1:0]      a_n_ff, a_n_in;
   logic                          b_valid_ff;
   logic [cdfd_pkg::N_W-1:0]      b_n_ff;
   logic [cdfd_pkg::Q_W-1:0]      b_q_ff, b_q_in;
   logic [cdfd_pkg::PROD_W-1:0]   prod;
   logic                          c_valid_ff;
   logic [cdfd_pkg::Q_W-1:0]      c_q_ff;
   logic [cdfd_pkg::R0_W-1:0]     c_r_ff, c_r_in;
   cdfd_pkg::era_type             era_ff, era_in;
   logic [cdfd_pkg::Q_W-1:0]      q_fix;
   logic [cdfd_pkg::R0_W-1:0]     r_fix;

   assign a_n_in = {in_days[cdfd_pkg::DAYS_W-1], in_days} + cdfd_pkg::N_OFFSET;

   assign prod   = cdfd_pkg::PROD_W'(a_n_ff[cdfd_pkg::N_W-1:cdfd_pkg::N_DROP])
                 * cdfd_pkg::PROD_W'(cdfd_pkg::RECIP_400Y);
   assign b_q_in = prod[cdfd_pkg::Q_SHIFT+cdfd_pkg::Q_W-1:cdfd_pkg::Q_SHIFT];

   // estimate is low by at most two eras
   assign c_r_in = b_n_ff[cdfd_pkg::R0_W-1:0]
                 - cdfd_pkg::R0_W'(36'(b_q_ff) * 36'(cdfd_pkg::DAYS_400Y));

   always_comb begin
      if (c_r_ff >= D2) begin
         q_fix = c_q_ff + cdfd_pkg::Q_W'(2);
         r_fix = c_r_ff - D2;
      end else if (c_r_ff >= D1) begin
         q_fix = c_q_ff + cdfd_pkg::Q_W'(1);
         r_fix = c_r_ff - D1;
      end else begin
         q_fix = c_q_ff;
         r_fix = c_r_ff;
      end
      era_in.valid = c_valid_ff;
      era_in.cyc   = cdfd_pkg::CYC_W'(q_fix) - cdfd_pkg::CYC_W'(cdfd_pkg::BIAS_ERAS);
      era_in.rem   = r_fix[cdfd_pkg::R_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         era_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= in_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         era_ff       <= era_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_n_ff     <= a_n_in;
         b_n_ff     <= a_n_ff;
         b_q_ff     <= b_q_in;
         c_q_ff     <= b_q_ff;
         c_r_ff     <= c_r_in;
      end
   end

   assign era = era_ff;

endmodule

`default_nettype wire

// ----- hdl/cdfd_year_split.sv -----
// four pipeline stages: century, four-year group count, group remainder, year
// splits the day within the era down to the day of the year; uses cdfd_pkg
`default_nettype none

module cdfd_year_split (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  cdfd_pkg::era_type  era,
   output cdfd_pkg::split_type split
);

   localparam logic [cdfd_pkg::R_W-1:0]  C1 = cdfd_pkg::R_W'(cdfd_pkg::DAYS_100Y);
   localparam logic [cdfd_pkg::R_W-1:0]  C2 = cdfd_pkg::R_W'(2 * cdfd_pkg::DAYS_100Y);
   localparam logic [cdfd_pkg::R_W-1:0]  C3 = cdfd_pkg::R_W'(3 * cdfd_pkg::DAYS_100Y);
   localparam logic [cdfd_pkg::R_W-1:0]  LEAP_Y = cdfd_pkg::R_W'(cdfd_pkg::DAYS_LEAP_Y);
   localparam logic [cdfd_pkg::R1_W-1:0] PLAIN_Y = cdfd_pkg::R1_W'(cdfd_pkg::DAYS_1Y);
   localparam logic [cdfd_pkg::R2_W-1:0] Y1 = cdfd_pkg::R2_W'(cdfd_pkg::DAYS_1Y);
   localparam logic [cdfd_pkg::R2_W-1:0] Y2 = cdfd_pkg::R2_W'(2 * cdfd_pkg::DAYS_1Y);
   localparam logic [cdfd_pkg::R2_W-1:0] Y3 = cdfd_pkg::R2_W'(3 * cdfd_pkg::DAYS_1Y);
   localparam logic [cdfd_pkg::R2_W-1:0] LEAP_Y2 = cdfd_pkg::R2_W'(cdfd_pkg::DAYS_LEAP_Y);

   // century stage
   logic                            e_valid_ff, e_f1_ff, e_f1_in;
   logic [cdfd_pkg::CYC_W-1:0]      e_cyc_ff;
   logic [cdfd_pkg::CENT_W-1:0]     e_cent_ff, e_cent_in;
   logic [cdfd_pkg::R1_W-1:0]       e_r1_ff, e_r1_in;
   logic [cdfd_pkg::R_W-1:0]        t_cent, cent_days;
   // four-year group count stage
   logic                            f_valid_ff, f_f2_ff, f_f2_in;
   logic [cdfd_pkg::CYC_W-1:0]      f_cyc_ff;
   logic [cdfd_pkg::CENT_W-1:0]     f_cent_ff;
   logic [cdfd_pkg::QUAD_W-1:0]     f_quad_ff, f_quad_in;
   logic [cdfd_pkg::R1_W-1:0]       f_u_ff, f_u_in, u_quad;
   // group remainder stage
   logic                            g_valid_ff, g_f2_ff;
   logic [cdfd_pkg::CYC_W-1:0]      g_cyc_ff;
   logic [cdfd_pkg::CENT_W-1:0]     g_cent_ff;
   logic [cdfd_pkg::QUAD_W-1:0]     g_quad_ff;
   logic [cdfd_pkg::R2_W-1:0]       g_r2_ff, g_r2_in;
   // year stage
   cdfd_pkg::split_type             split_ff, split_in;
   logic                            f3;
   logic [cdfd_pkg::R2_W-1:0]       t_yr, yr_days;

   always_comb begin
      e_f1_in = era.rem >= LEAP_Y;
      t_cent  = era.rem - cdfd_pkg::R_W'(1);
      if (!e_f1_in) begin
         e_cent_in = '0;
         cent_days = '0;
      end else if (t_cent >= C3) begin
         e_cent_in = cdfd_pkg::CENT_W'(3);
         cent_days = C3;
      end else if (t_cent >= C2) begin
         e_cent_in = cdfd_pkg::CENT_W'(2);
         cent_days = C2;
      end else if (t_cent >= C1) begin
         e_cent_in = cdfd_pkg::CENT_W'(1);
         cent_days = C1;
      end else begin
         e_cent_in = '0;
         cent_days = '0;
      end
      e_r1_in = e_f1_in ? cdfd_pkg::R1_W'(t_cent - cent_days)
                        : cdfd_pkg::R1_W'(era.rem);
   end

   always_comb begin
      f_f2_in   = e_f1_ff && (e_r1_ff >= PLAIN_Y);
      u_quad    = e_r1_ff + cdfd_pkg::R1_W'(1);
      f_quad_in = '0;
      if (f_f2_in) begin
         for (int k = 1; k <= cdfd_pkg::QUADS_PER_CENT; k++) begin
            f_quad_in = f_quad_in
                      + cdfd_pkg::QUAD_W'(u_quad >= cdfd_pkg::R1_W'(k * cdfd_pkg::DAYS_4Y));
         end
      end
      f_u_in = f_f2_in ? u_quad : e_r1_ff;
   end

   assign g_r2_in = cdfd_pkg::R2_W'(f_u_ff
                  - cdfd_pkg::R1_W'(f_quad_ff * cdfd_pkg::R1_W'(cdfd_pkg::DAYS_4Y)));

   always_comb begin
      f3   = g_f2_ff && (g_r2_ff >= LEAP_Y2);
      t_yr = g_r2_ff - cdfd_pkg::R2_W'(1);
      if (!f3) begin
         split_in.yr = '0;
         yr_days     = '0;
      end else if (t_yr >= Y3) begin
         split_in.yr = cdfd_pkg::YR_W'(3);
         yr_days     = Y3;
      end else if (t_yr >= Y2) begin
         split_in.yr = cdfd_pkg::YR_W'(2);
         yr_days     = Y2;
      end else if (t_yr >= Y1) begin
         split_in.yr = cdfd_pkg::YR_W'(1);
         yr_days     = Y1;
      end else begin
         split_in.yr = '0;
         yr_days     = '0;
      end
      split_in.valid = g_valid_ff;
      split_in.cyc   = g_cyc_ff;
      split_in.cent  = g_cent_ff;
      split_in.quad  = g_quad_ff;
      split_in.doy   = f3 ? cdfd_pkg::DOY_W'(t_yr - yr_days)
                          : cdfd_pkg::DOY_W'(g_r2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff     <= 1'b0;
         f_valid_ff     <= 1'b0;
         g_valid_ff     <= 1'b0;
         split_ff.valid <= 1'b0;
      end else if (en) begin
         e_valid_ff     <= era.valid;
         f_valid_ff     <= e_valid_ff;
         g_valid_ff     <= f_valid_ff;
         split_ff       <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_cyc_ff      <= era.cyc;
         e_cent_ff     <= e_cent_in;
         e_r1_ff       <= e_r1_in;
         e_f1_ff       <= e_f1_in;
         f_cyc_ff      <= e_cyc_ff;
         f_cent_ff     <= e_cent_ff;
         f_quad_ff     <= f_quad_in;
         f_u_ff        <= f_u_in;
         f_f2_ff       <= f_f2_in;
         g_cyc_ff      <= f_cyc_ff;
         g_cent_ff     <= f_cent_ff;
         g_quad_ff     <= f_quad_ff;
         g_r2_ff       <= g_r2_in;
         g_f2_ff       <= f_f2_ff;
      end
   end

   assign split = split_ff;

endmodule

`default_nettype wire

// ----- hdl/cdfd_date_out.sv -----
// result register stage: year assembly, leap flag, month and day of month
// fed by cdfd_year_split; uses cdfd_pkg
`default_nettype none

module cdfd_date_out (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  cdfd_pkg::split_type               split,
   output logic                              out_valid,
   output logic [cdfd_pkg::YEAR_W-1:0]       out_year,
   output logic [cdfd_pkg::MONTH_W-1:0]      out_month,
   output logic [cdfd_pkg::MDAY_W-1:0]      out_mday,
   output logic [cdfd_pkg::DOY_W-1:0]        out_doy
);

   logic                             valid_ff;
   logic [cdfd_pkg::YEAR_W-1:0]      year_ff, year_in;
   logic [cdfd_pkg::MONTH_W-1:0]     month_ff, month_in, mon_idx;
   logic [cdfd_pkg::MDAY_W-1:0]      mday_ff, mday_in;
   logic [cdfd_pkg::DOY_W-1:0]       doy_ff, month_base;
   logic                             leap;

   always_comb begin
      year_in = cdfd_pkg::YEAR_W'(cdfd_pkg::BASE_YEAR)
              + cdfd_pkg::YEAR_W'({{(cdfd_pkg::YEAR_W-cdfd_pkg::CYC_W){split.cyc[cdfd_pkg::CYC_W-1]}},
                                   split.cyc} * cdfd_pkg::YEAR_W'(cdfd_pkg::YEARS_ERA))
              + cdfd_pkg::YEAR_W'(split.cent) * cdfd_pkg::YEAR_W'(cdfd_pkg::YEARS_CENT)
              + cdfd_pkg::YEAR_W'(split.quad) * cdfd_pkg::YEAR_W'(cdfd_pkg::YEARS_QUAD)
              + cdfd_pkg::YEAR_W'(split.yr);
      // first year of a group is leap unless it starts a century other than the era's first
      leap = (split.yr == '0) && ((split.quad != '0) || (split.cent == '0));
      mon_idx = '0;
      for (int m = 1; m < cdfd_pkg::MONTHS; m++) begin
         mon_idx = mon_idx + cdfd_pkg::MONTH_W'(split.doy >=
                   cdfd_pkg::month_start(leap, cdfd_pkg::MONTH_W'(m)));
      end
      month_base = cdfd_pkg::month_start(leap, mon_idx);
      month_in   = mon_idx + cdfd_pkg::MONTH_W'(1);
      mday_in    = cdfd_pkg::MDAY_W'(split.doy - month_base) + cdfd_pkg::MDAY_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= split.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         mday_ff  <= mday_in;
         doy_ff   <= split.doy;
      end
   end

   assign out_valid = valid_ff;
   assign out_year  = year_ff;
   assign out_month = month_ff;
   assign out_mday  = mday_ff;
   assign out_doy   = doy_ff;

endmodule

`default_nettype wire

// ----- hdl/civil_date_from_days.sv -----
// civil_date_from_days: signed day count since 1970-01-01 to proleptic gregorian date
// top level; instantiates cdfd_era_split, cdfd_year_split, cdfd_date_out; uses cdfd_pkg
//
// req channel carries one signed 32-bit day count per item, rsp channel one date per item
// rsp_tdata holds year, month, day of month and day of year
// the block is a ten-register pipeline: input register, four era stages,
// four year stages and the result register
// an item accepted into the input register shows on rsp_tvalid once it reaches the result register
// throughput is one item per cycle while rsp_tready does not stall the pipe; every stage moves on the same enable
// the enable is high whenever the result register is empty or being taken,
// so a new item is accepted in the same cycle that the last result leaves
// when the receiver holds rsp_tready low with a result waiting, the whole pipe
// freezes, req_tready drops and nothing in flight is lost or repeated
// reset clears every stage valid bit; data registers are not reset
// and there is no clearing pass, so req_tready is high right after reset
// the pipe carries no state between items
`default_nettype none

module civil_date_from_days (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // days_since_epoch [31:0]
   input  wire logic [cdfd_pkg::DAYS_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // year [23:0], month [27:24], day_of_month [32:28], day_of_year [41:33], zero [47:42]
   output logic [cdfd_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   logic                              en;
   logic                              in_valid_ff;
   logic [cdfd_pkg::DAYS_W-1:0]       in_days_ff;
   cdfd_pkg::era_type                 era;
   cdfd_pkg::split_type               split;
   logic [cdfd_pkg::YEAR_W-1:0]       year;
   logic [cdfd_pkg::MONTH_W-1:0]      month;
   logic [cdfd_pkg::MDAY_W-1:0]       mday;
   logic [cdfd_pkg::DOY_W-1:0]        doy;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_days_ff <= req_tdata;
      end
   end

   cdfd_era_split u_era (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_valid_ff),
      .in_days  (in_days_ff),
      .era      (era)
   );

   cdfd_year_split u_year (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .era   (era),
      .split (split)
   );

   cdfd_date_out u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .split     (split),
      .out_valid (rsp_tvalid),
      .out_year  (year),
      .out_month (month),
      .out_mday  (mday),
      .out_doy   (doy)
   );

   assign rsp_tdata = {(cdfd_pkg::RSP_DATA_W - cdfd_pkg::RSP_FIELDS_W)'(0),
                       doy, mday, month, year};

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (month != '0) && (month <= cdfd_pkg::MONTH_W'(cdfd_pkg::MONTHS)))
      else $error("month out of range");

   a_day_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mday != '0)
                     && (doy <= cdfd_pkg::DOY_W'(cdfd_pkg::DAYS_1Y)))
      else $error("day of month or day of year out of range");

endmodule

`default_nettype wire

// ----- tb/tb_civil_date_from_days.sv -----
// self-checking testbench for civil_date_from_days: directed table, then random day counts
// every rsp item is checked against the table or an in-file date predictor; depends on cdfd_pkg and the rtl
`timescale 1ns / 1ps

module tb_civil_date_from_days;

   localparam longint EPOCH_TO_2000 = 365 * 30 + 7;
   localparam longint ERA_DAYS      = 400 * 365 + 100 - 4 + 1;
   localparam longint CENT_DAYS     = 100 * 365 + 25 - 1;
   localparam longint QUAD_DAYS     = 4 * 365 + 1;
   localparam longint ERA_BASE_YEAR = 2000;
   localparam int     CYCLE_LIMIT   = 200000;
   localparam int     PHASE_ITEMS   = 317;
   localparam int     DRAIN_CYCLES  = 20;
   localparam int     NUM_DIRECTED  = 24;

   typedef struct packed {
      logic [23:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [8:0]  doy;
   } civil_date_type;

   typedef struct packed {
      logic [31:0]    days;
      logic           typed;
      civil_date_type date;
   } directed_row_type;

   typedef struct packed {
      logic [31:0]    days;
      civil_date_type date;
   } pending_date_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // days_since_epoch [31:0]
   logic [cdfd_pkg::DAYS_W-1:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // year [23:0], month [27:24], day_of_month [32:28], day_of_year [41:33], zero [47:42]
   logic [cdfd_pkg::RSP_DATA_W-1:0] rsp_tdata;

   pending_date_type pending_dates[$];
   int               errors = 0;
   int               cycles = 0;
   int               send_idle = 0;
   int               recv_idle = 0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{32'sd0,           1'b1, '{24'sd1970, 4'd1,  5'd1,  9'd0}},
      '{-32'sd1,          1'b1, '{24'sd1969, 4'd12, 5'd31, 9'd364}},
      '{32'sd10956,       1'b1, '{24'sd1999, 4'd12, 5'd31, 9'd364}},
      '{32'sd10957,       1'b1, '{24'sd2000, 4'd1,  5'd1,  9'd0}},
      '{32'sd11016,       1'b1, '{24'sd2000, 4'd2,  5'd29, 9'd59}},
      '{32'sd11322,       1'b1, '{24'sd2000, 4'd12, 5'd31, 9'd365}},
      '{-32'sd25567,      1'b1, '{24'sd1900, 4'd1,  5'd1,  9'd0}},
      '{-32'sd719528,     1'b1, '{24'sd0,    4'd1,  5'd1,  9'd0}},
      '{-32'sd719529,     1'b1, '{-24'sd1,   4'd12, 5'd31, 9'd364}},
      '{32'h7fffffff,     1'b0, '0},
      '{32'h80000000,     1'b0, '0},
      '{32'h7ffffffe,     1'b0, '0},
      '{32'h80000001,     1'b0, '0},
      '{32'h55555555,     1'b0, '0},
      '{32'haaaaaaaa,     1'b0, '0},
      '{32'sd47481,       1'b0, '0},
      '{32'sd47482,       1'b0, '0},
      '{32'sd47540,       1'b0, '0},
      '{32'sd47541,       1'b0, '0},
      '{32'sd157053,      1'b0, '0},
      '{32'sd157054,      1'b0, '0},
      '{-32'sd135140,     1'b0, '0},
      '{-32'sd135141,     1'b0, '0},
      '{32'sd12418,       1'b0, '0}
   };

   civil_date_from_days i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int month_length(input logic leap, input int mon);
      case (mon)
         2:            return leap ? 29 : 28;
         4, 6, 9, 11:  return 30;
         default:      return 31;
      endcase
   endfunction

   function automatic civil_date_type civil_from_days(input logic [31:0] days);
      longint         d;
      longint         era;
      longint         r;
      longint         yr;
      longint         rem;
      int             mon;
      logic           leap;
      civil_date_type res;
      d = longint'($signed(days)) - EPOCH_TO_2000;
      era = d / ERA_DAYS;
      r = d % ERA_DAYS;
      if (r < 0) begin
         r += ERA_DAYS;
         era -= 1;
      end
      yr = ERA_BASE_YEAR + 400 * era;
      if (r >= 366) begin
         yr += 100 * ((r - 1) / CENT_DAYS);
         r = (r - 1) % CENT_DAYS;
         if (r >= 365) begin
            yr += 4 * ((r + 1) / QUAD_DAYS);
            r = (r + 1) % QUAD_DAYS;
            if (r >= 366) begin
               yr += (r - 1) / 365;
               r = (r - 1) % 365;
            end
         end
      end
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      rem = r;
      mon = 1;
      while (mon < 12 && rem >= month_length(leap, mon)) begin
         rem -= month_length(leap, mon);
         mon++;
      end
      res.year = yr[23:0];
      res.month = mon[3:0];
      res.mday = 5'(rem + 1);
      res.doy = r[8:0];
      return res;
   endfunction

   task automatic send_day(input logic [31:0] days, input civil_date_type date);
      pending_date_type entry;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= days;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      entry.days = days;
      entry.date = date;
      pending_dates.push_back(entry);
   endtask

   task automatic wait_all_dates;
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_day;
      longint d;
      case ($urandom_range(0, 3))
         0: d = longint'($signed($urandom));
         1: d = longint'($urandom_range(0, 200000)) - 100000;
         // near era, century, four-year and year boundaries, incl. end of february
         2: d = EPOCH_TO_2000
                + (longint'($urandom_range(0, 28000)) - 14000) * ERA_DAYS
                + longint'($urandom_range(0, 3)) * CENT_DAYS
                + longint'($urandom_range(0, 24)) * QUAD_DAYS
                + longint'($urandom_range(0, 3)) * 365
                + longint'($urandom_range(0, 64)) - 2;
         default: d = $urandom_range(0, 1) ? longint'(32'h7ff00000 + $urandom_range(0, 20'hfffff))
                                           : -longint'(32'h80000000) + $urandom_range(0, 20'hfffff);
      endcase
      return d[31:0];
   endfunction

   task automatic report_field(input string name, input logic [31:0] days,
                               input longint want, input longint got);
      errors++;
      $display("%0t: day %0d %s expected %0d actual %0d", $time, $signed(days), name, want, got);
   endtask

   always @(posedge clock) begin
      pending_date_type entry;
      civil_date_type   got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.year  = rsp_tdata[23:0];
         got.month = rsp_tdata[27:24];
         got.mday  = rsp_tdata[32:28];
         got.doy   = rsp_tdata[41:33];
         if (pending_dates.size() == 0) begin
            errors++;
            $display("%0t: unexpected item expected none actual %h", $time, rsp_tdata);
         end else begin
            entry = pending_dates.pop_front();
            if (got.year !== entry.date.year)
               report_field("year", entry.days, $signed(entry.date.year), $signed(got.year));
            if (got.month !== entry.date.month)
               report_field("month", entry.days, entry.date.month, got.month);
            if (got.mday !== entry.date.mday)
               report_field("day_of_month", entry.days, entry.date.mday, got.mday);
            if (got.doy !== entry.date.doy)
               report_field("day_of_year", entry.days, entry.date.doy, got.doy);
            if (rsp_tdata[47:42] !== 6'd0)
               report_field("pad", entry.days, 0, rsp_tdata[47:42]);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle = 38;
      recv_idle = 63;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].typed)
            send_day(directed_rows[i].days, directed_rows[i].date);
         else
            send_day(directed_rows[i].days, civil_from_days(directed_rows[i].days));
      end
      for (int phase = 0; phase < 3; phase++) begin
         // hold off until the pipe has drained before each phase
         wait_all_dates();
         send_idle = (phase == 0) ? 38 : (phase == 1) ? 63 : 0;
         recv_idle = (phase == 0) ? 63 : (phase == 1) ? 38 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            logic [31:0] days;
            days = random_day();
            send_day(days, civil_from_days(days));
         end
      end
      wait_all_dates();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/cdfd_pkg.sv
hdl/cdfd_era_split.sv
hdl/cdfd_year_split.sv
hdl/cdfd_date_out.sv
hdl/civil_date_from_days.sv
tb/tb_civil_date_from_days.sv
